@@ design/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue: entry layout,
// request kinds and result status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default number of cells in the queue
    localparam int CAPACITY_DEF = 16;

    // Field widths of a request and a result
    localparam int PRI_W = 8;
    localparam int AGE_W = 7;
    localparam int SEX_W = 8;
    localparam int TAG_W = 16;
    localparam int OCC_W = 5;

    // Request kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PUSHED = 2'd0,
        ST_POPPED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // One stored entry
    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [AGE_W-1:0] age;
        logic [SEX_W-1:0] sex;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

endpackage

@@ design/spq_ifs.sv @@
// ----------------------------------------------------------------------------
// spq_ifs
// Valid/ready channels of the stable priority queue: request and result.
// ----------------------------------------------------------------------------

// Request channel: push or pop
interface spq_req_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [spq_pkg::PRI_W-1:0]     priority_req;
    logic [spq_pkg::AGE_W-1:0]     age;
    logic [spq_pkg::SEX_W-1:0]     sex;
    logic [spq_pkg::TAG_W-1:0]     tag;

    modport source (output valid, kind, priority_req, age, sex, tag, input ready);
    modport sink   (input valid, kind, priority_req, age, sex, tag, output ready);
endinterface

// Result channel: one result per request
interface spq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [spq_pkg::PRI_W-1:0]     out_priority;
    logic [spq_pkg::AGE_W-1:0]     out_age;
    logic [spq_pkg::SEX_W-1:0]     out_sex;
    logic [spq_pkg::TAG_W-1:0]     out_tag;
    logic [spq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, status, out_priority, out_age, out_sex, out_tag,
                    occupancy, input ready);
    modport sink   (input valid, status, out_priority, out_age, out_sex, out_tag,
                    occupancy, output ready);
endinterface

@@ design/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. It compares the pushed priority with its own
// entry, and on each command takes the new entry, its left neighbor's entry
// (shift up on push) or its right neighbor's entry (shift down on pop).
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  spq_pkg::t_entry    i_new,
    input  logic               i_occ,
    input  spq_pkg::t_entry    i_left,
    input  logic               i_left_ins,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_ins
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // Flag cells that the new entry goes at or before: empty, or strictly greater
    assign o_ins = !i_occ || (i_new.pri < r_entry.pri);

    // Pick the next entry: new, shifted up from the left, or shifted down
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push && o_ins) begin
            n_entry = i_left_ins ? i_left : i_new;
        end else if (i_ctl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ design/stable_priority_queue_top.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Bounded priority queue kept sorted by ascending priority in a chain of
// cells; equal priorities leave first in, first out.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  i_req     in    valid/ready     kind, priority_req, age, sex, tag
//  o_rsp     out   valid/ready     status, out_priority, out_age, out_sex,
//                                  out_tag, occupancy
//
//  One request is taken per cycle when no result stalls; all cells compare
//  and shift in that cycle. Its result appears on o_rsp, from a register,
//  in the cycle after acceptance. A stalled result holds i_req.ready low
//  until taken; no other stall source. Reset clears the entry count and the
//  result valid flag and holds i_req.ready low; cells need no clear.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_req_if.sink   i_req,
    spq_rsp_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    spq_pkg::t_cell_ctl w_ctl;
    spq_pkg::t_entry    w_new;
    spq_pkg::t_entry    w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_ins;
    logic                w_accept;
    logic                w_full;
    logic                w_empty;

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;

    logic                r_out_valid;
    spq_pkg::t_status    r_status;
    spq_pkg::t_status    n_status;
    spq_pkg::t_entry     r_out_entry;
    spq_pkg::t_entry     n_out_entry;
    logic [spq_pkg::OCC_W-1:0] r_occ;

    // Accept out of reset while the result register is free or being drained
    assign i_req.ready = i_rst_n && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    assign w_new.pri = i_req.priority_req;
    assign w_new.age = i_req.age;
    assign w_new.sex = i_req.sex;
    assign w_new.tag = i_req.tag;

    // Decode the request into a push or pop command
    always_comb begin
        w_ctl.push  = 1'b0;
        w_ctl.pop   = 1'b0;
        n_count     = r_count;
        n_status    = spq_pkg::ST_PUSHED;
        n_out_entry = '0;
        if (i_req.kind == spq_pkg::KIND_PUSH) begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                w_ctl.push = w_accept;
                n_count    = r_count + CW'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                w_ctl.pop   = w_accept;
                n_status    = spq_pkg::ST_POPPED;
                n_out_entry = w_entry[0];
                n_count     = r_count - CW'(1);
            end
        end
    end

    // Build the chain of cells, head at index zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_ins;

        if (g == 0) begin : g_head
            assign w_left     = w_new;
            assign w_left_ins = 1'b0;
        end else begin : g_body
            assign w_left     = w_entry[g-1];
            assign w_left_ins = w_ins[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_entry[g];
        end else begin : g_inner
            assign w_right = w_entry[g+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_new      (w_new),
            .i_occ      (r_count > CW'(g)),
            .i_left     (w_left),
            .i_left_ins (w_left_ins),
            .i_right    (w_right),
            .o_entry    (w_entry[g]),
            .o_ins      (w_ins[g])
        );
    end

    // Track the number of held entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_entry <= n_out_entry;
            r_occ       <= spq_pkg::OCC_W'(n_count);
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_status;
    assign o_rsp.out_priority = r_out_entry.pri;
    assign o_rsp.out_age      = r_out_entry.age;
    assign o_rsp.out_sex      = r_out_entry.sex;
    assign o_rsp.out_tag      = r_out_entry.tag;
    assign o_rsp.occupancy    = r_occ;

endmodule

@@ design/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                i_status,
    input logic [spq_pkg::PRI_W-1:0] i_pri,
    input logic [spq_pkg::AGE_W-1:0] i_age,
    input logic [spq_pkg::SEX_W-1:0] i_sex,
    input logic [spq_pkg::TAG_W-1:0] i_tag,
    input logic [spq_pkg::OCC_W-1:0] i_occ
);

    // Hold a stalled result steady
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_pri) && $stable(i_occ)))
        else $error("stalled result changed");

    // Take no request while a result is stalled
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !(i_in_valid && i_in_ready))
        else $error("request taken over a stalled result");

    // Zero the data fields of every result that is not a pop
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != spq_pkg::ST_POPPED) |->
            (i_pri == '0 && i_age == '0 && i_sex == '0 && i_tag == '0))
        else $error("non-pop result carries data");

    // Report an empty pop only with nothing held
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == spq_pkg::ST_EMPTY) |-> (i_occ == '0))
        else $error("empty pop with entries held");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_pri       (o_rsp.out_priority),
    .i_age       (o_rsp.out_age),
    .i_sex       (o_rsp.out_sex),
    .i_tag       (o_rsp.out_tag),
    .i_occ       (o_rsp.occupancy)
);

@@ tb/sv/stable_priority_queue_top_tb.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_top_tb
// Self-checking bench for the stable priority queue. A short table of
// directed requests (pop on empty, field extremes, equal priorities, fill to
// full and a push into the full queue) is followed by random bursts that
// fill, drain and mix requests. Each accepted request is run through a
// sorted software copy of the queue, and every result is compared field by
// field with the oldest expected one. Both channels stall at random, the
// result side once for a long stretch, and the sender once waits until
// every result is back.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_tb;

    localparam int DEPTH       = spq_pkg::CAPACITY_DEF;
    localparam int RAND_ITEMS  = 600;
    localparam int CALM_ITEMS  = 60;
    localparam int LONG_HOLD   = 120;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    // Expected result of one request
    typedef struct packed {
        spq_pkg::t_status          status;
        logic [spq_pkg::PRI_W-1:0] pri;
        logic [spq_pkg::AGE_W-1:0] age;
        logic [spq_pkg::SEX_W-1:0] sex;
        logic [spq_pkg::TAG_W-1:0] tag;
        logic [spq_pkg::OCC_W-1:0] occ;
    } t_result;

    // One request, with an optional hand-written result
    typedef struct packed {
        logic            kind;
        spq_pkg::t_entry ent;
        logic            pinned;
        t_result         want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    stable_priority_queue_top #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    spq_pkg::t_entry sorted_cells[$];     // software copy of the queue, head first
    t_result         pending_results[$];  // results still owed by the block
    t_row            request_table[$];
    int unsigned     n_errors;
    int unsigned     n_results;
    int unsigned     n_cycles;
    int unsigned     req_idle_pct;
    int unsigned     rsp_idle_pct;
    int unsigned     rsp_gap;
    int unsigned     rsp_hold;

    // Clock
    always #2 i_clk = ~i_clk;

    // Known inputs from time zero, reset held at the start
    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.kind         = spq_pkg::KIND_PUSH;
        req_if.priority_req = '0;
        req_if.age          = '0;
        req_if.sex          = '0;
        req_if.tag          = '0;
        rsp_if.ready        = 1'b0;
        n_errors            = 0;
        n_results           = 0;
        n_cycles            = 0;
        req_idle_pct        = 0;
        rsp_idle_pct        = 0;
        rsp_gap             = 0;
        rsp_hold            = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", n_cycles,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, n_results, msg);
        n_errors++;
    endtask

    // Apply one request to the sorted copy and return its result
    function automatic t_result serve_request(input logic kind,
                                              input spq_pkg::t_entry ent);
        t_result         res;
        spq_pkg::t_entry head;
        int              pos;
        res = '0;
        if (kind == spq_pkg::KIND_PUSH) begin
            if (sorted_cells.size() >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                // insert behind every entry of lower or equal priority
                pos = sorted_cells.size();
                while (pos > 0 && ent.pri < sorted_cells[pos-1].pri)
                    pos--;
                sorted_cells.insert(pos, ent);
                res.status = spq_pkg::ST_PUSHED;
            end
        end else begin
            if (sorted_cells.size() == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                head       = sorted_cells.pop_front();
                res.status = spq_pkg::ST_POPPED;
                res.pri    = head.pri;
                res.age    = head.age;
                res.sex    = head.sex;
                res.tag    = head.tag;
            end
        end
        res.occ = spq_pkg::OCC_W'(sorted_cells.size());
        return res;
    endfunction

    // Offer one request, wait for it to be taken, then record its result
    task automatic send_request(input t_row row);
        int unsigned gap;
        t_result     res;
        if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
            gap = $urandom_range(1, 19);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.kind         <= row.kind;
        req_if.priority_req <= row.ent.pri;
        req_if.age          <= row.ent.age;
        req_if.sex          <= row.ent.sex;
        req_if.tag          <= row.ent.tag;
        do @(posedge i_clk); while (!(req_if.valid && req_if.ready));
        res = serve_request(row.kind, row.ent);
        pending_results.push_back(row.pinned ? row.want : res);
    endtask

    task automatic add_row(input logic kind, input spq_pkg::t_entry ent,
                           input logic pinned = 1'b0, input t_result want = '0);
        t_row row;
        row.kind   = kind;
        row.ent    = ent;
        row.pinned = pinned;
        row.want   = want;
        request_table.push_back(row);
    endtask

    // Result side: random stall bursts, one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (rsp_hold != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_hold--;
        end else if (rsp_gap != 0) begin
            rsp_if.ready <= 1'b0;
            rsp_gap--;
        end else if (rsp_idle_pct != 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_if.ready <= 1'b0;
            rsp_gap = $urandom_range(1, 19) - 1;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Compare each taken result with the oldest one owed
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result arrived with none expected");
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch($sformatf("status got %0h want %0h",
                                              rsp_if.status, want.status));
                if (rsp_if.out_priority !== want.pri)
                    report_mismatch($sformatf("out_priority got %0h want %0h",
                                              rsp_if.out_priority, want.pri));
                if (rsp_if.out_age !== want.age)
                    report_mismatch($sformatf("out_age got %0h want %0h",
                                              rsp_if.out_age, want.age));
                if (rsp_if.out_sex !== want.sex)
                    report_mismatch($sformatf("out_sex got %0h want %0h",
                                              rsp_if.out_sex, want.sex));
                if (rsp_if.out_tag !== want.tag)
                    report_mismatch($sformatf("out_tag got %0h want %0h",
                                              rsp_if.out_tag, want.tag));
                if (rsp_if.occupancy !== want.occ)
                    report_mismatch($sformatf("occupancy got %0d want %0d",
                                              rsp_if.occupancy, want.occ));
            end
            n_results++;
        end
    end

    // Stimulus
    initial begin : drive_requests
        t_row        row;
        int unsigned n_random;
        int unsigned mode;
        int unsigned burst;
        int unsigned push_pct;
        bit          held_off;
        bit          drained;

        // directed table: empty pop, extremes, ties, fill, full push, pops
        add_row(spq_pkg::KIND_POP,  '{8'hFF, 7'h7F, 8'hFF, 16'hFFFF}, 1'b1,
                '{spq_pkg::ST_EMPTY, 8'd0, 7'd0, 8'd0, 16'h0000, 5'd0});
        add_row(spq_pkg::KIND_PUSH, '{8'hFF, 7'h7F, 8'hFF, 16'hFFFF}, 1'b1,
                '{spq_pkg::ST_PUSHED, 8'd0, 7'd0, 8'd0, 16'h0000, 5'd1});
        add_row(spq_pkg::KIND_PUSH, '{8'h00, 7'h00, 8'h00, 16'h0000}, 1'b1,
                '{spq_pkg::ST_PUSHED, 8'd0, 7'd0, 8'd0, 16'h0000, 5'd2});
        add_row(spq_pkg::KIND_PUSH, '{8'h80, 7'h55, 8'hAA, 16'h5555});
        add_row(spq_pkg::KIND_PUSH, '{8'h80, 7'h2A, 8'h55, 16'hAAAA});
        add_row(spq_pkg::KIND_PUSH, '{8'h00, 7'h01, 8'h01, 16'h0001});
        add_row(spq_pkg::KIND_PUSH, '{8'hFF, 7'h02, 8'h02, 16'h0002});
        add_row(spq_pkg::KIND_PUSH, '{8'h40, 7'h03, 8'h03, 16'h0003});
        add_row(spq_pkg::KIND_PUSH, '{8'hC8, 7'h04, 8'h04, 16'h0004});
        add_row(spq_pkg::KIND_PUSH, '{8'h01, 7'h05, 8'h05, 16'h0005});
        add_row(spq_pkg::KIND_PUSH, '{8'hFE, 7'h06, 8'h06, 16'h0006});
        add_row(spq_pkg::KIND_PUSH, '{8'h80, 7'h07, 8'h07, 16'h0007});
        add_row(spq_pkg::KIND_PUSH, '{8'h7F, 7'h08, 8'h08, 16'h0008});
        add_row(spq_pkg::KIND_PUSH, '{8'h81, 7'h09, 8'h09, 16'h0009});
        add_row(spq_pkg::KIND_PUSH, '{8'h00, 7'h0A, 8'h0A, 16'h000A});
        add_row(spq_pkg::KIND_PUSH, '{8'hFF, 7'h0B, 8'h0B, 16'h000B});
        add_row(spq_pkg::KIND_PUSH, '{8'h64, 7'h0C, 8'h0C, 16'h000C});
        add_row(spq_pkg::KIND_PUSH, '{8'h10, 7'h0D, 8'h0D, 16'h000D}, 1'b1,
                '{spq_pkg::ST_FULL, 8'd0, 7'd0, 8'd0, 16'h0000, 5'd16});
        add_row(spq_pkg::KIND_POP,  '{8'hFF, 7'h7F, 8'hFF, 16'hFFFF}, 1'b1,
                '{spq_pkg::ST_POPPED, 8'd0, 7'd0, 8'd0, 16'h0000, 5'd15});
        add_row(spq_pkg::KIND_POP,  '{8'h00, 7'h00, 8'h00, 16'h0000}, 1'b1,
                '{spq_pkg::ST_POPPED, 8'd0, 7'd1, 8'd1, 16'h0001, 5'd14});
        add_row(spq_pkg::KIND_POP,  '{8'h5A, 7'h5A, 8'h5A, 16'h5A5A});

        wait (i_rst_n);
        @(posedge i_clk);

        req_idle_pct = 20;
        rsp_idle_pct = 20;
        foreach (request_table[i])
            send_request(request_table[i]);

        // random bursts that fill, drain or mix
        n_random = 0;
        held_off = 1'b0;
        drained  = 1'b0;
        while (n_random < RAND_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(5, 40);
            case (mode)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            if (n_random + CALM_ITEMS >= RAND_ITEMS) begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0:       req_idle_pct = 0;
                    1:       req_idle_pct = 5;
                    2:       req_idle_pct = 15;
                    default: req_idle_pct = 40;
                endcase
                case ($urandom_range(0, 3))
                    0:       rsp_idle_pct = 0;
                    1:       rsp_idle_pct = 5;
                    2:       rsp_idle_pct = 15;
                    default: rsp_idle_pct = 40;
                endcase
            end

            // hold results off for a long stretch while requests keep coming
            if (!held_off && n_random >= 200) begin
                rsp_hold = LONG_HOLD;
                held_off = 1'b1;
            end

            // pause requests until every result is back
            if (!drained && n_random >= 400) begin
                req_if.valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(posedge i_clk);
                drained = 1'b1;
            end

            repeat (burst) begin
                row.kind   = ($urandom_range(0, 99) < push_pct) ?
                             spq_pkg::KIND_PUSH : spq_pkg::KIND_POP;
                row.pinned = 1'b0;
                row.want   = '0;
                case ($urandom_range(0, 3))
                    0:       row.ent.pri = 8'($urandom_range(0, 3));
                    1:       row.ent.pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    default: row.ent.pri = 8'($urandom);
                endcase
                row.ent.age = 7'($urandom);
                row.ent.sex = 8'($urandom);
                row.ent.tag = 16'($urandom);
                send_request(row);
                n_random++;
            end
        end

        // drain and settle
        req_if.valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/spq_pkg.sv
design/spq_ifs.sv
design/spq_cell.sv
design/stable_priority_queue_top.sv
design/spq_checker.sv
tb/sv/stable_priority_queue_top_tb.sv
